FILE: hdl/cckp_pkg.sv
// Shared types, constants and helper functions for the calendar clock with keypad edit.
package cckp_pkg;

    localparam int YEAR_W   = 14;
    localparam int TIME_W   = 7;
    localparam int TENTH_W  = 4;
    localparam int CURSOR_W = 3;
    localparam int COUNT_W  = 3;
    localparam int KEY_W    = 4;
    localparam int OUT_W    = 72;

    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
    localparam logic [TIME_W-1:0] TIME_MAX = 7'd127;

    localparam logic [3:0] KEY_A    = 4'd10;
    localparam logic [3:0] KEY_B    = 4'd11;
    localparam logic [3:0] KEY_C    = 4'd12;
    localparam logic [3:0] KEY_D    = 4'd13;
    localparam logic [3:0] KEY_STAR = 4'd14;
    localparam logic [3:0] KEY_HASH = 4'd15;

    localparam logic [CURSOR_W-1:0] CUR_MONTH  = 3'd0;
    localparam logic [CURSOR_W-1:0] CUR_DAY    = 3'd1;
    localparam logic [CURSOR_W-1:0] CUR_YEAR   = 3'd2;
    localparam logic [CURSOR_W-1:0] CUR_HOUR   = 3'd3;
    localparam logic [CURSOR_W-1:0] CUR_MINUTE = 3'd4;
    localparam logic [CURSOR_W-1:0] CUR_SECOND = 3'd5;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [TIME_W-1:0]  month;
        logic [TIME_W-1:0]  day;
        logic [TIME_W-1:0]  hour;
        logic [TIME_W-1:0]  minute;
        logic [TIME_W-1:0]  second;
        logic [TENTH_W-1:0] tenth;
    } clk_state_t;

    typedef struct packed {
        logic                edit;
        logic [CURSOR_W-1:0] cursor;
        logic                mode24;
        logic [YEAR_W-1:0]   entry;
        logic [COUNT_W-1:0]  count;
    } ui_state_t;

    // keypad position to key code
    function automatic logic [3:0] key_code(input logic [KEY_W-1:0] idx);
        logic [3:0] c;
        case (idx)
            4'd0:    c = 4'd1;
            4'd1:    c = 4'd2;
            4'd2:    c = 4'd3;
            4'd3:    c = KEY_A;
            4'd4:    c = 4'd4;
            4'd5:    c = 4'd5;
            4'd6:    c = 4'd6;
            4'd7:    c = KEY_B;
            4'd8:    c = 4'd7;
            4'd9:    c = 4'd8;
            4'd10:   c = 4'd9;
            4'd11:   c = KEY_C;
            4'd12:   c = KEY_STAR;
            4'd13:   c = 4'd0;
            4'd14:   c = KEY_HASH;
            default: c = KEY_D;
        endcase
        return c;
    endfunction

    // out-of-range months count 31 days
    function automatic logic [TIME_W-1:0] month_len(input logic [TIME_W-1:0] m);
        logic [TIME_W-1:0] l;
        case (m)
            7'd1:    l = 7'd28;
            7'd3:    l = 7'd30;
            7'd5:    l = 7'd30;
            7'd8:    l = 7'd30;
            7'd10:   l = 7'd30;
            default: l = 7'd31;
        endcase
        return l;
    endfunction

    // divisibility by 25 by folding: 128 = 3 and 32 = 7 (mod 25)
    function automatic logic div25(input logic [YEAR_W-1:0] y);
        logic [8:0] r1;
        logic [7:0] r2;
        r1 = {2'b0, y[13:7]} + {1'b0, y[13:7], 1'b0} + {2'b0, y[6:0]};
        r2 = {1'b0, r1[8:5], 3'b0} - {4'b0, r1[8:5]} + {3'b0, r1[4:0]};
        return (r2 == 8'd0) || (r2 == 8'd25) || (r2 == 8'd50) || (r2 == 8'd75)
            || (r2 == 8'd100) || (r2 == 8'd125);
    endfunction

    function automatic logic [TIME_W-1:0] inc_time(input logic [TIME_W-1:0] v);
        return (v >= TIME_MAX) ? TIME_MAX : v + 7'd1;
    endfunction

    function automatic logic [YEAR_W-1:0] inc_year(input logic [YEAR_W-1:0] v);
        return (v >= YEAR_MAX) ? YEAR_MAX : v + 14'd1;
    endfunction

    function automatic logic [TIME_W-1:0] cap_time(input logic [YEAR_W-1:0] v);
        return (v > {7'd0, TIME_MAX}) ? TIME_MAX : v[TIME_W-1:0];
    endfunction

endpackage

FILE: hdl/cckp_tick.sv
// Next clock state for one tenth-second tick, with carries up to the year.
module cckp_tick (
    input  cckp_pkg::clk_state_t cur,
    output cckp_pkg::clk_state_t nxt
);

    logic leap;

    assign leap = (cur.year[1:0] == 2'd0) && (cur.month == 7'd1)
               && (!cckp_pkg::div25(cur.year) || (cur.year[3:0] == 4'd0));

    always_comb begin
        nxt = cur;
        if (({1'b0, cur.tenth} + 5'd1) >= 5'd10) begin
            nxt.tenth  = '0;
            nxt.second = cckp_pkg::inc_time(cur.second);
        end else begin
            nxt.tenth = cur.tenth + 4'd1;
        end
        if (nxt.second >= 7'd60) begin
            nxt.second = '0;
            nxt.minute = cckp_pkg::inc_time(nxt.minute);
        end
        if (nxt.minute >= 7'd60) begin
            nxt.minute = '0;
            nxt.hour   = cckp_pkg::inc_time(nxt.hour);
        end
        if (nxt.hour >= 7'd24) begin
            nxt.hour = '0;
            nxt.day  = cckp_pkg::inc_time(nxt.day);
        end
        // leap February keeps day 28
        if (nxt.day >= cckp_pkg::month_len(nxt.month)) begin
            if (!leap || (nxt.day > 7'd28)) begin
                nxt.day   = '0;
                nxt.month = cckp_pkg::inc_time(nxt.month);
            end
        end
        if (nxt.month >= 7'd12) begin
            nxt.month = '0;
            nxt.year  = cckp_pkg::inc_year(nxt.year);
        end
    end

endmodule

FILE: hdl/cckp_key.sv
// Next clock and edit state for one key press.
module cckp_key (
    input  cckp_pkg::clk_state_t         cur_clk,
    input  cckp_pkg::ui_state_t          cur_ui,
    input  logic [cckp_pkg::KEY_W-1:0]   key_index,
    output cckp_pkg::clk_state_t         nxt_clk,
    output cckp_pkg::ui_state_t          nxt_ui
);

    logic [3:0]                     code;
    logic [16:0]                    entry_wide;
    logic [cckp_pkg::YEAR_W-1:0]    entry_sat;
    logic [cckp_pkg::COUNT_W-1:0]   count_inc;
    logic                           store;

    assign code       = cckp_pkg::key_code(key_index);
    assign entry_wide = {cur_ui.entry, 3'b0} + {2'b0, cur_ui.entry, 1'b0} + {13'd0, code};
    assign entry_sat  = (entry_wide > {3'd0, cckp_pkg::YEAR_MAX}) ? cckp_pkg::YEAR_MAX
                                                                  : entry_wide[13:0];
    assign count_inc  = (cur_ui.count < 3'd7) ? cur_ui.count + 3'd1 : cur_ui.count;
    assign store      = ((cur_ui.cursor == cckp_pkg::CUR_YEAR) && (count_inc == 3'd4))
                     || ((cur_ui.cursor != cckp_pkg::CUR_YEAR) && (count_inc == 3'd2));

    always_comb begin
        nxt_clk = cur_clk;
        nxt_ui  = cur_ui;
        if (code == cckp_pkg::KEY_C) begin
            nxt_ui.mode24 = !cur_ui.mode24;
        end else if (code == cckp_pkg::KEY_D) begin
            nxt_ui.edit  = !cur_ui.edit;
            nxt_ui.entry = '0;
            nxt_ui.count = '0;
        end else if (cur_ui.edit) begin
            if (code == cckp_pkg::KEY_HASH) begin
                if (cur_ui.cursor < cckp_pkg::CUR_SECOND) begin
                    nxt_ui.cursor = cur_ui.cursor + 3'd1;
                end
            end else if (code == cckp_pkg::KEY_STAR) begin
                if (cur_ui.cursor > cckp_pkg::CUR_MONTH) begin
                    nxt_ui.cursor = cur_ui.cursor - 3'd1;
                end
            end else if (code == cckp_pkg::KEY_A) begin
                case (cur_ui.cursor)
                    cckp_pkg::CUR_MONTH:  nxt_clk.month  = cckp_pkg::inc_time(cur_clk.month);
                    cckp_pkg::CUR_DAY:    nxt_clk.day    = cckp_pkg::inc_time(cur_clk.day);
                    cckp_pkg::CUR_YEAR:   nxt_clk.year   = cckp_pkg::inc_year(cur_clk.year);
                    cckp_pkg::CUR_HOUR:   nxt_clk.hour   = cckp_pkg::inc_time(cur_clk.hour);
                    cckp_pkg::CUR_MINUTE: nxt_clk.minute = cckp_pkg::inc_time(cur_clk.minute);
                    cckp_pkg::CUR_SECOND: nxt_clk.second = cckp_pkg::inc_time(cur_clk.second);
                    default: ;
                endcase
            end else if (code == cckp_pkg::KEY_B) begin
                case (cur_ui.cursor)
                    cckp_pkg::CUR_MONTH: begin
                        if (cur_clk.month != '0) nxt_clk.month = cur_clk.month - 7'd1;
                    end
                    cckp_pkg::CUR_DAY: begin
                        if (cur_clk.day != '0) nxt_clk.day = cur_clk.day - 7'd1;
                    end
                    cckp_pkg::CUR_YEAR: begin
                        if (cur_clk.year != '0) nxt_clk.year = cur_clk.year - 14'd1;
                    end
                    cckp_pkg::CUR_HOUR: begin
                        if (cur_clk.hour != '0) nxt_clk.hour = cur_clk.hour - 7'd1;
                    end
                    cckp_pkg::CUR_MINUTE: begin
                        if (cur_clk.minute != '0) nxt_clk.minute = cur_clk.minute - 7'd1;
                    end
                    cckp_pkg::CUR_SECOND: begin
                        if (cur_clk.second != '0) nxt_clk.second = cur_clk.second - 7'd1;
                    end
                    default: ;
                endcase
            end else begin
                nxt_ui.count = count_inc;
                nxt_ui.entry = entry_sat;
                if (store) begin
                    nxt_ui.count = '0;
                    nxt_ui.entry = '0;
                    case (cur_ui.cursor)
                        cckp_pkg::CUR_MONTH: begin
                            if (entry_sat != '0) nxt_clk.month = cckp_pkg::cap_time(entry_sat - 14'd1);
                        end
                        cckp_pkg::CUR_DAY: begin
                            if (entry_sat != '0) nxt_clk.day = cckp_pkg::cap_time(entry_sat - 14'd1);
                        end
                        cckp_pkg::CUR_YEAR:   nxt_clk.year   = entry_sat;
                        cckp_pkg::CUR_HOUR:   nxt_clk.hour   = cckp_pkg::cap_time(entry_sat);
                        cckp_pkg::CUR_MINUTE: nxt_clk.minute = cckp_pkg::cap_time(entry_sat);
                        cckp_pkg::CUR_SECOND: nxt_clk.second = cckp_pkg::cap_time(entry_sat);
                        default: ;
                    endcase
                end
            end
        end
    end

endmodule

FILE: hdl/calendar_clock_with_keypad_edit.sv
// Top level of the calendar clock with keypad edit: input register, state and result register.
//
// Input channel s_*: one transfer is a tenth-second tick (s_tuser = 0) or a key press
// (s_tuser = 1, keypad position in s_tdata[3:0]). Result channel m_*: one transfer per
// input transfer, carrying the whole clock and edit state after that item.
// An item is registered on entry, and the state update and result capture happen as it
// moves from the input register to the result register, which waits while a held result
// is not taken; m_tvalid rises with that capture.
// Throughput is one item per cycle while m_tready is high; the tick/key next-state logic
// between the input register and the state/result registers is combinational.
// If m_tready is held low the result register holds, the input register fills and
// s_tready drops after one more transfer; nothing is lost or repeated.
// Reset (aresetn low, synchronous) clears the calendar to year 0, month 0, day 0,
// 00:00:00.0, leaves edit mode, cursor on the month, 12-hour display, empty entry,
// and empties both pipeline registers.
module calendar_clock_with_keypad_edit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] key_index, [7:4] zero
    input  logic        s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [13:0] year_out, [20:14] month_out, [27:21] day_out,
                                   // [34:28] hour_out, [41:35] minute_out, [48:42] second_out,
                                   // [52:49] tenth_out, [53] editing, [56:54] cursor,
                                   // [70:57] entry_out, [71] twenty_four_hour
);

    logic                           in_valid_reg;
    logic                           in_op_reg;
    logic [cckp_pkg::KEY_W-1:0]     in_key_reg;
    cckp_pkg::clk_state_t           clk_reg, clk_next, tick_clk, key_clk;
    cckp_pkg::ui_state_t            ui_reg, ui_next, key_ui;
    logic                           out_valid_reg;
    logic [cckp_pkg::OUT_W-1:0]     out_data_reg, out_data_next;
    logic                           advance;
    logic                           step;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    cckp_tick u_tick (
        .cur (clk_reg),
        .nxt (tick_clk)
    );

    cckp_key u_key (
        .cur_clk   (clk_reg),
        .cur_ui    (ui_reg),
        .key_index (in_key_reg),
        .nxt_clk   (key_clk),
        .nxt_ui    (key_ui)
    );

    assign clk_next = in_op_reg ? key_clk : tick_clk;
    assign ui_next  = in_op_reg ? key_ui  : ui_reg;

    assign out_data_next = {ui_next.mode24, ui_next.entry, ui_next.cursor, ui_next.edit,
                            clk_next.tenth, clk_next.second, clk_next.minute, clk_next.hour,
                            clk_next.day, clk_next.month, clk_next.year};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            clk_reg       <= '0;
            ui_reg        <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (step) begin
                clk_reg <= clk_next;
                ui_reg  <= ui_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg  <= s_tuser;
            in_key_reg <= s_tdata[3:0];
        end
        if (step) begin
            out_data_reg <= out_data_next;
        end
    end

    a_step_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> m_tvalid)
        else $error("processed item produced no result");

    a_stall_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a pending result");

    a_entry_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !ui_reg.edit |-> ((ui_reg.entry == '0) && (ui_reg.count == '0)))
        else $error("entry held outside edit mode");

    a_ranges: assert property (@(posedge aclk) disable iff (!aresetn)
        (clk_reg.tenth <= 4'd9) && (ui_reg.cursor <= cckp_pkg::CUR_SECOND)
        && (clk_reg.year <= cckp_pkg::YEAR_MAX) && (ui_reg.entry <= cckp_pkg::YEAR_MAX))
        else $error("clock or edit state out of range");

endmodule

FILE: verif/tb_top.sv
// Testbench for the calendar clock with keypad edit: directed and random items against a predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int ITEM_TARGET  = 800;
    localparam int QUIET_FROM   = 680;
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_KEY     = 1'b1;
    localparam int TIME_LIM     = int'(cckp_pkg::TIME_MAX);
    localparam int YEAR_LIM     = int'(cckp_pkg::YEAR_MAX);

    // key code per keypad position, position 0 in the low nibble
    localparam logic [63:0] KEYPAD_MAP = {cckp_pkg::KEY_D, cckp_pkg::KEY_HASH, 4'd0,
                                          cckp_pkg::KEY_STAR,
                                          cckp_pkg::KEY_C, 4'd9, 4'd8, 4'd7,
                                          cckp_pkg::KEY_B, 4'd6, 4'd5, 4'd4,
                                          cckp_pkg::KEY_A, 4'd3, 4'd2, 4'd1};
    // month lengths, January in the low byte
    localparam logic [95:0] MONTH_DAYS = {8'd31, 8'd30, 8'd31, 8'd30, 8'd31, 8'd31,
                                          8'd30, 8'd31, 8'd30, 8'd31, 8'd28, 8'd31};

    // result layout, highest field first
    typedef struct packed {
        logic                          mode24;
        logic [cckp_pkg::YEAR_W-1:0]   entry;
        logic [cckp_pkg::CURSOR_W-1:0] cursor;
        logic                          edit;
        logic [cckp_pkg::TENTH_W-1:0]  tenth;
        logic [cckp_pkg::TIME_W-1:0]   second, minute, hour, day, month;
        logic [cckp_pkg::YEAR_W-1:0]   year;
    } calendar_view_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;

    calendar_view_t               calendar_now = '0;
    logic [cckp_pkg::COUNT_W-1:0] digit_count = '0;
    calendar_view_t               expected_views[$];
    int                           effective_items = 0;
    int                           error_count = 0;
    int                           ready_stall = 0;
    bit                           idle_on = 1'b1;

    calendar_clock_with_keypad_edit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    task automatic flag_error(input string msg);
        $display("%0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want) begin
            flag_error($sformatf("%s: got %0d, want %0d", name, got, want));
        end
    endtask

    // ---------------- predictor ----------------

    function automatic logic [3:0] code_at(input logic [3:0] pos);
        return KEYPAD_MAP[int'(pos)*4 +: 4];
    endfunction

    function automatic logic [3:0] position_of(input logic [3:0] code);
        for (int p = 0; p < 16; p++) begin
            if (code_at(4'(p)) == code) return 4'(p);
        end
        return 4'd0;
    endfunction

    function automatic int days_in(input int month);
        if (month >= 12) return 31;
        return int'(MONTH_DAYS[month*8 +: 8]);
    endfunction

    function automatic int step_up(input int v, input int lim);
        return (v >= lim) ? lim : v + 1;
    endfunction

    function automatic int field_limit(input logic [cckp_pkg::CURSOR_W-1:0] cur);
        return (cur == cckp_pkg::CUR_YEAR) ? YEAR_LIM : TIME_LIM;
    endfunction

    function automatic int field_value(input logic [cckp_pkg::CURSOR_W-1:0] cur);
        case (cur)
            cckp_pkg::CUR_MONTH:  return int'(calendar_now.month);
            cckp_pkg::CUR_DAY:    return int'(calendar_now.day);
            cckp_pkg::CUR_YEAR:   return int'(calendar_now.year);
            cckp_pkg::CUR_HOUR:   return int'(calendar_now.hour);
            cckp_pkg::CUR_MINUTE: return int'(calendar_now.minute);
            cckp_pkg::CUR_SECOND: return int'(calendar_now.second);
            default:              return 0;
        endcase
    endfunction

    task automatic write_field(input logic [cckp_pkg::CURSOR_W-1:0] cur, input int v);
        case (cur)
            cckp_pkg::CUR_MONTH:  calendar_now.month  = 7'(v);
            cckp_pkg::CUR_DAY:    calendar_now.day    = 7'(v);
            cckp_pkg::CUR_YEAR:   calendar_now.year   = 14'(v);
            cckp_pkg::CUR_HOUR:   calendar_now.hour   = 7'(v);
            cckp_pkg::CUR_MINUTE: calendar_now.minute = 7'(v);
            cckp_pkg::CUR_SECOND: calendar_now.second = 7'(v);
            default: ;
        endcase
    endtask

    task automatic advance_tenth();
        int  t;
        int  y;
        bit  leap_feb;
        t = int'(calendar_now.tenth) + 1;
        if (t >= 10) begin
            t = 0;
            calendar_now.second = 7'(step_up(int'(calendar_now.second), TIME_LIM));
        end
        calendar_now.tenth = 4'(t);
        if (calendar_now.second >= 60) begin
            calendar_now.second = '0;
            calendar_now.minute = 7'(step_up(int'(calendar_now.minute), TIME_LIM));
        end
        if (calendar_now.minute >= 60) begin
            calendar_now.minute = '0;
            calendar_now.hour = 7'(step_up(int'(calendar_now.hour), TIME_LIM));
        end
        if (calendar_now.hour >= 24) begin
            calendar_now.hour = '0;
            calendar_now.day = 7'(step_up(int'(calendar_now.day), TIME_LIM));
        end
        if (int'(calendar_now.day) >= days_in(int'(calendar_now.month))) begin
            y = int'(calendar_now.year);
            leap_feb = (y % 4 == 0) && (calendar_now.month == 1) &&
                       ((y % 100 != 0) || (y % 400 == 0));
            if (!leap_feb || calendar_now.day > 28) begin
                calendar_now.day = '0;
                calendar_now.month = 7'(step_up(int'(calendar_now.month), TIME_LIM));
            end
        end
        if (calendar_now.month >= 12) begin
            calendar_now.month = '0;
            calendar_now.year = 14'(step_up(int'(calendar_now.year), YEAR_LIM));
        end
    endtask

    task automatic apply_key(input logic [3:0] pos);
        logic [3:0] code;
        int         v;
        int         lim;
        code = code_at(pos);
        if (code == cckp_pkg::KEY_C) begin
            calendar_now.mode24 = ~calendar_now.mode24;
        end else if (code == cckp_pkg::KEY_D) begin
            calendar_now.edit = ~calendar_now.edit;
            calendar_now.entry = '0;
            digit_count = '0;
        end else if (calendar_now.edit) begin
            case (code)
                cckp_pkg::KEY_HASH: begin
                    if (calendar_now.cursor < cckp_pkg::CUR_SECOND) calendar_now.cursor++;
                end
                cckp_pkg::KEY_STAR: begin
                    if (calendar_now.cursor > cckp_pkg::CUR_MONTH) calendar_now.cursor--;
                end
                cckp_pkg::KEY_A: write_field(calendar_now.cursor,
                                             step_up(field_value(calendar_now.cursor),
                                                     field_limit(calendar_now.cursor)));
                cckp_pkg::KEY_B: begin
                    if (field_value(calendar_now.cursor) > 0)
                        write_field(calendar_now.cursor, field_value(calendar_now.cursor) - 1);
                end
                default: begin
                    if (digit_count < 7) digit_count++;
                    v = int'(calendar_now.entry) * 10 + int'(code);
                    if (v > YEAR_LIM) v = YEAR_LIM;
                    calendar_now.entry = 14'(v);
                    if ((calendar_now.cursor == cckp_pkg::CUR_YEAR && digit_count == 4) ||
                        (calendar_now.cursor != cckp_pkg::CUR_YEAR && digit_count == 2)) begin
                        lim = field_limit(calendar_now.cursor);
                        if (calendar_now.cursor == cckp_pkg::CUR_MONTH ||
                            calendar_now.cursor == cckp_pkg::CUR_DAY) begin
                            if (v > 0) write_field(calendar_now.cursor,
                                                   (v - 1 > lim) ? lim : v - 1);
                        end else begin
                            write_field(calendar_now.cursor, (v > lim) ? lim : v);
                        end
                        calendar_now.entry = '0;
                        digit_count = '0;
                    end
                end
            endcase
        end
    endtask

    task automatic predict_item(input logic op, input logic [3:0] pos);
        logic [3:0] code;
        code = code_at(pos);
        // keys other than C and D do nothing outside edit mode
        if (op == OP_TICK || calendar_now.edit || code == cckp_pkg::KEY_C
            || code == cckp_pkg::KEY_D)
            effective_items++;
        if (op == OP_KEY) apply_key(pos);
        else advance_tenth();
        expected_views.push_back(calendar_now);
    endtask

    // ---------------- driving ----------------

    task automatic send_item(input logic op, input logic [3:0] pos);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'd0, pos};
        do @(posedge aclk); while (s_tready !== 1'b1);
        predict_item(op, pos);
    endtask

    always @(negedge aclk) begin
        if (ready_stall > 0) ready_stall--;
        else if (idle_on && $urandom_range(0, 5) == 0) ready_stall = $urandom_range(1, 11);
        m_tready <= (ready_stall == 0);
    end

    always @(posedge aclk) begin : check_results
        calendar_view_t got;
        calendar_view_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            got = m_tdata;
            if (expected_views.size() == 0) begin
                flag_error("result transfer with nothing expected");
            end else begin
                want = expected_views.pop_front();
                compare_field("year",   int'(got.year),   int'(want.year));
                compare_field("month",  int'(got.month),  int'(want.month));
                compare_field("day",    int'(got.day),    int'(want.day));
                compare_field("hour",   int'(got.hour),   int'(want.hour));
                compare_field("minute", int'(got.minute), int'(want.minute));
                compare_field("second", int'(got.second), int'(want.second));
                compare_field("tenth",  int'(got.tenth),  int'(want.tenth));
                compare_field("editing", int'(got.edit),  int'(want.edit));
                compare_field("cursor", int'(got.cursor), int'(want.cursor));
                compare_field("entry",  int'(got.entry),  int'(want.entry));
                compare_field("twenty_four_hour", int'(got.mode24), int'(want.mode24));
            end
        end
    end

    // ---------------- stimulus helpers ----------------

    task automatic press(input logic [3:0] code);
        send_item(OP_KEY, position_of(code));
    endtask

    task automatic tick_n(input int n);
        repeat (n) send_item(OP_TICK, 4'($urandom_range(0, 15)));
    endtask

    // ends in edit mode with an empty entry
    task automatic enter_edit_clean();
        if (calendar_now.edit) press(cckp_pkg::KEY_D);
        press(cckp_pkg::KEY_D);
    endtask

    task automatic move_cursor(input int target);
        while (int'(calendar_now.cursor) < target) press(cckp_pkg::KEY_HASH);
        while (int'(calendar_now.cursor) > target) press(cckp_pkg::KEY_STAR);
    endtask

    task automatic dial_field(input logic [cckp_pkg::CURSOR_W-1:0] cur, input int value);
        int div;
        if (!calendar_now.edit || digit_count != 0) enter_edit_clean();
        move_cursor(int'(cur));
        div = (cur == cckp_pkg::CUR_YEAR) ? 1000 : 10;
        while (div > 0) begin
            press(4'((value / div) % 10));
            div = div / 10;
        end
    endtask

    function automatic int non_year_field();
        int cur;
        cur = $urandom_range(0, 4);
        if (cur >= int'(cckp_pkg::CUR_YEAR)) cur++;
        return cur;
    endfunction

    // ---------------- tests ----------------

    task automatic test_keypad_outside_edit();
        for (int p = 0; p < 15; p++) send_item(OP_KEY, 4'(p));
        send_item(OP_TICK, 4'hF);
        send_item(OP_TICK, 4'h0);
    endtask

    task automatic test_edit_corners();
        press(cckp_pkg::KEY_D);
        press(cckp_pkg::KEY_B);      // field already at zero
        press(cckp_pkg::KEY_STAR);   // cursor already at the bottom
        press(cckp_pkg::KEY_A);
        press(cckp_pkg::KEY_B);
        press(cckp_pkg::KEY_C);
        press(cckp_pkg::KEY_D);
    endtask

    // fields set close to a carry, then ticked through it
    task automatic test_rollover();
        int yr;
        int mo_entry;
        int day_entry;
        int r;
        enter_edit_clean();
        case ($urandom_range(0, 8))
            0: yr = 2000;
            1: yr = 1900;
            2: yr = 2024;
            3: yr = 2023;
            4: yr = 2100;
            5: yr = 9999;
            6: yr = 0;
            7: yr = 2400;
            default: yr = $urandom_range(0, 9999);
        endcase
        if ($urandom_range(0, 3) != 0) dial_field(cckp_pkg::CUR_YEAR, yr);
        r = $urandom_range(0, 9);
        if (r <= 2) mo_entry = 2;
        else if (r <= 4) mo_entry = 12;
        else if (r == 5) mo_entry = 0;
        else if (r == 6) mo_entry = $urandom_range(13, 99);
        else mo_entry = $urandom_range(1, 12);
        dial_field(cckp_pkg::CUR_MONTH, mo_entry);
        r = $urandom_range(0, 9);
        if (r <= 5) day_entry = days_in(int'(calendar_now.month));
        else if (r == 6) day_entry = days_in(int'(calendar_now.month)) + 1;
        else if (r == 7) day_entry = 99;
        else day_entry = $urandom_range(0, 99);
        dial_field(cckp_pkg::CUR_DAY, day_entry);
        dial_field(cckp_pkg::CUR_HOUR,
                   ($urandom_range(0, 9) < 7) ? 23 : $urandom_range(0, 99));
        dial_field(cckp_pkg::CUR_MINUTE,
                   ($urandom_range(0, 9) < 7) ? 59 : $urandom_range(0, 99));
        dial_field(cckp_pkg::CUR_SECOND,
                   ($urandom_range(0, 9) < 7) ? 59 : $urandom_range(0, 99));
        if ($urandom_range(0, 3) != 0) press(cckp_pkg::KEY_D);
        tick_n($urandom_range(1, 25));
    endtask

    task automatic test_saturation();
        int cur;
        enter_edit_clean();
        cur = $urandom_range(0, 5);
        if (cur == int'(cckp_pkg::CUR_YEAR)) dial_field(3'(cur), $urandom_range(9985, 9999));
        else dial_field(3'(cur), $urandom_range(90, 99));
        repeat ($urandom_range(1, 40)) press(cckp_pkg::KEY_A);
        if ($urandom_range(0, 1)) begin
            dial_field(3'(cur), $urandom_range(0, 3));
            repeat ($urandom_range(1, 5)) press(cckp_pkg::KEY_B);
        end
        repeat ($urandom_range(0, 8))
            press($urandom_range(0, 1) ? cckp_pkg::KEY_HASH : cckp_pkg::KEY_STAR);
        press(cckp_pkg::KEY_D);
        tick_n($urandom_range(1, 12));
    endtask

    // cursor moved in the middle of typing a value
    task automatic test_stuck_entry();
        enter_edit_clean();
        if ($urandom_range(0, 1)) begin
            move_cursor(int'(cckp_pkg::CUR_YEAR));
            repeat (2) press(4'($urandom_range(0, 9)));
            move_cursor(non_year_field());
            repeat ($urandom_range(3, 8)) press(4'($urandom_range(0, 9)));
        end else begin
            move_cursor(non_year_field());
            press(4'($urandom_range(0, 9)));
            move_cursor(int'(cckp_pkg::CUR_YEAR));
            repeat (3) press(4'($urandom_range(0, 9)));
        end
        press(cckp_pkg::KEY_D);
    endtask

    task automatic test_noise();
        repeat ($urandom_range(10, 40))
            send_item(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = 1'b0;
        s_tdata  = 8'd0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_keypad_outside_edit();
        test_edit_corners();
        while (effective_items < ITEM_TARGET) begin
            if (effective_items >= QUIET_FROM) idle_on = 1'b0;
            else idle_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: test_rollover();
                5, 6:          test_saturation();
                7:             test_stuck_entry();
                default:       test_noise();
            endcase
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (expected_views.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("tb_top: errors");
        $finish;
    end

endmodule
